// ----- sv/positional_list_engine_macros.svh -----
// Assertion macros for the positional list engine.
// Needs i_clk and i_rst_n in the scope of use.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define PEL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional_list_engine: check failed");
`define PEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional_list_engine: check failed");
`else
`define PEL_ASSERT_IMPL(label, ante, cons)
`define PEL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/pel_pkg.sv -----
// Package for the positional list engine: defaults, codes and FSM state type.
// No dependencies.
package pel_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        A_INS_FRONT = 3'd0,
        A_INS_BACK  = 3'd1,
        A_INS_POS   = 3'd2,
        A_DEL_FRONT = 3'd3,
        A_DEL_BACK  = 3'd4,
        A_DEL_POS   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_RD,
        S_INS_W1,
        S_INS_W2,
        S_DEL_RD,
        S_DEL_W,
        S_RESP
    } t_state;

endpackage

// ----- sv/positional_list_engine.sv -----
// Positional list engine: circular doubly linked list over slot memories.
// Depends on pel_pkg and positional_list_engine_macros.svh.
//
// One operation at a time. Front and back inserts and a back delete skip the
// walk; a front delete passes through the walk state unless it is also the back
// entry. A positional operation walks the forward-link memory one entry per
// cycle from the head. A new item is taken only in the idle state; a finished
// result waits in the output register while the next item runs.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
    parameter int CAPACITY   = pel_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = pel_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_position,
    input  logic signed [31:0] i_item_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [6:0]  o_result_position,
    output logic signed [31:0] o_result_value,
    output logic [6:0]  o_entry_total
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;
    localparam int EW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    logic [VALUE_BITS-1:0] m_val  [CAPACITY];
    logic [SW-1:0]         m_fwd  [CAPACITY];
    logic [SW-1:0]         m_bwd  [CAPACITY];
    logic [SW-1:0]         m_free [CAPACITY];

    pel_pkg::t_state r_state, n_state;

    logic [SW-1:0]         r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count, r_top, n_top, r_low, n_low;
    logic                  r_ins, n_ins, r_first, n_first;
    logic [CW-1:0]         r_pos, n_pos, r_left, n_left;
    logic [SW-1:0]         r_cur, n_cur, r_node, n_node, r_next, n_next;
    logic [VALUE_BITS-1:0] r_sval, n_sval;
    pel_pkg::t_status      r_res_status, n_res_status;
    logic [CW-1:0]         r_res_pos, n_res_pos;
    logic [31:0]           r_res_val, n_res_val;

    logic                  r_o_valid, n_o_valid;
    logic [1:0]            r_o_status;
    logic [6:0]            r_o_pos, r_o_total;
    logic [31:0]           r_o_val;

    logic [VALUE_BITS-1:0] r_val_q;
    logic [SW-1:0]         r_fwd_q, r_bwd_q, r_free_q;
    logic [SW-1:0]         fwd_ra, bwd_ra, val_ra, free_ra;
    logic                  fwd_we, bwd_we, val_we, free_we;
    logic [SW-1:0]         fwd_wa, fwd_wd, bwd_wa, bwd_wd, val_wa, free_wa, free_wd;
    logic [VALUE_BITS-1:0] val_wd;

    logic                  accept, out_free;
    logic [PW-1:0]         pos_x, cnt_x, p_ins, p_del;
    logic [SW-1:0]         walk_c, pop_node;
    logic [CW-1:0]         top_m1;
    logic signed [EW-1:0]  in_ext;

    function automatic logic [31:0] shown(input logic [VALUE_BITS-1:0] v);
        logic signed [VALUE_BITS-1:0] s;
        logic signed [EW-1:0]         e;
        s = v;
        e = EW'(s);
        return e[31:0];
    endfunction

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != pel_pkg::S_IDLE);
    assign pos_x    = PW'(i_position);
    assign cnt_x    = PW'(r_count);
    assign in_ext   = EW'(i_item_value);
    assign walk_c   = r_first ? r_cur : r_fwd_q;
    assign top_m1   = r_top - 1'b1;
    assign pop_node = (top_m1 >= r_low) ? r_free_q
                                        : SW'(CW'(CAPACITY - 1) - top_m1);

    always_comb begin
        unique case (pel_pkg::t_action'(i_action))
            pel_pkg::A_INS_FRONT: p_ins = PW'(1);
            pel_pkg::A_INS_BACK:  p_ins = cnt_x + 1'b1;
            default: begin
                if (pos_x == '0) p_ins = PW'(1);
                else if (pos_x > cnt_x + 1'b1) p_ins = cnt_x + 1'b1;
                else p_ins = pos_x;
            end
        endcase
        unique case (pel_pkg::t_action'(i_action))
            pel_pkg::A_DEL_FRONT: p_del = PW'(1);
            pel_pkg::A_DEL_BACK:  p_del = cnt_x;
            default:              p_del = pos_x;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pel_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (pel_pkg::t_action'(i_action))
                        pel_pkg::A_INS_FRONT, pel_pkg::A_INS_BACK,
                        pel_pkg::A_INS_POS: begin
                            if (r_count == CW'(CAPACITY)) n_state = pel_pkg::S_RESP;
                            else if (r_count == '0 || p_ins == PW'(1) ||
                                     p_ins == cnt_x + 1'b1) n_state = pel_pkg::S_INS_RD;
                            else n_state = pel_pkg::S_WALK;
                        end
                        pel_pkg::A_DEL_FRONT, pel_pkg::A_DEL_BACK,
                        pel_pkg::A_DEL_POS: begin
                            if (r_count == '0 || p_del == '0 || p_del > cnt_x)
                                n_state = pel_pkg::S_RESP;
                            else if (p_del == cnt_x) n_state = pel_pkg::S_DEL_RD;
                            else n_state = pel_pkg::S_WALK;
                        end
                        default: n_state = pel_pkg::S_RESP;
                    endcase
                end
            end
            pel_pkg::S_WALK: begin
                if (r_left == '0) n_state = r_ins ? pel_pkg::S_INS_RD : pel_pkg::S_DEL_RD;
            end
            pel_pkg::S_INS_RD: n_state = pel_pkg::S_INS_W1;
            pel_pkg::S_INS_W1: n_state = pel_pkg::S_INS_W2;
            pel_pkg::S_INS_W2: n_state = pel_pkg::S_RESP;
            pel_pkg::S_DEL_RD: n_state = pel_pkg::S_DEL_W;
            pel_pkg::S_DEL_W:  n_state = pel_pkg::S_RESP;
            pel_pkg::S_RESP: begin
                if (out_free) n_state = pel_pkg::S_IDLE;
            end
            default: n_state = pel_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_head = r_head;  n_tail = r_tail;  n_count = r_count;
        n_top = r_top;    n_low = r_low;    n_ins = r_ins;
        n_first = r_first; n_pos = r_pos;   n_left = r_left;
        n_cur = r_cur;    n_node = r_node;  n_next = r_next;
        n_sval = r_sval;
        n_res_status = r_res_status; n_res_pos = r_res_pos; n_res_val = r_res_val;
        n_o_valid = r_o_valid && i_stall;
        fwd_ra = r_cur;  bwd_ra = r_cur;  val_ra = r_cur;  free_ra = SW'(top_m1);
        fwd_we = 1'b0;   fwd_wa = r_cur;  fwd_wd = r_node;
        bwd_we = 1'b0;   bwd_wa = r_cur;  bwd_wd = r_node;
        val_we = 1'b0;   val_wa = r_node; val_wd = r_sval;
        free_we = 1'b0;  free_wa = SW'(r_top); free_wd = r_cur;
        unique case (r_state)
            pel_pkg::S_IDLE: begin
                n_sval       = VALUE_BITS'(in_ext);
                n_first      = 1'b1;
                n_res_status = pel_pkg::ST_OK;
                n_res_pos    = '0;
                n_res_val    = '0;
                unique case (pel_pkg::t_action'(i_action))
                    pel_pkg::A_INS_FRONT, pel_pkg::A_INS_BACK,
                    pel_pkg::A_INS_POS: begin
                        n_ins  = 1'b1;
                        n_pos  = CW'(p_ins);
                        n_left = CW'(p_ins - PW'(2));
                        n_cur  = (p_ins == PW'(1) || p_ins == cnt_x + 1'b1) ? r_tail : r_head;
                        if (r_count == CW'(CAPACITY)) n_res_status = pel_pkg::ST_FULL;
                    end
                    pel_pkg::A_DEL_FRONT, pel_pkg::A_DEL_BACK,
                    pel_pkg::A_DEL_POS: begin
                        n_ins  = 1'b0;
                        n_pos  = CW'(p_del);
                        n_left = CW'(p_del - PW'(1));
                        n_cur  = (p_del == cnt_x) ? r_tail : r_head;
                        if (r_count == '0) n_res_status = pel_pkg::ST_EMPTY;
                        else if (p_del == '0 || p_del > cnt_x)
                            n_res_status = pel_pkg::ST_BADPOS;
                    end
                    default: n_res_status = pel_pkg::ST_BADPOS;
                endcase
            end
            pel_pkg::S_WALK: begin
                fwd_ra  = walk_c;
                n_cur   = walk_c;
                n_first = 1'b0;
                if (r_left != '0) n_left = r_left - 1'b1;
            end
            pel_pkg::S_INS_RD: begin
                fwd_ra = r_cur;
            end
            pel_pkg::S_INS_W1: begin
                n_node = pop_node;
                n_next = (r_count == '0) ? pop_node : r_fwd_q;
                n_cur  = (r_count == '0) ? pop_node : r_cur;
                val_we = 1'b1; val_wa = pop_node; val_wd = r_sval;
                fwd_we = 1'b1; fwd_wa = pop_node; fwd_wd = n_next;
                bwd_we = 1'b1; bwd_wa = pop_node; bwd_wd = n_cur;
            end
            pel_pkg::S_INS_W2: begin
                fwd_we = 1'b1; fwd_wa = r_cur;  fwd_wd = r_node;
                bwd_we = 1'b1; bwd_wa = r_next; bwd_wd = r_node;
                if (r_count == '0) begin
                    n_head = r_node;
                    n_tail = r_node;
                end else begin
                    if (r_pos == CW'(1)) n_head = r_node;
                    if (r_cur == r_tail && r_pos != CW'(1)) n_tail = r_node;
                end
                n_count   = r_count + 1'b1;
                n_top     = top_m1;
                if (top_m1 < r_low) n_low = top_m1;
                n_res_pos = r_pos;
                n_res_val = shown(r_sval);
            end
            pel_pkg::S_DEL_RD: begin
                fwd_ra = r_cur; bwd_ra = r_cur; val_ra = r_cur;
            end
            pel_pkg::S_DEL_W: begin
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    fwd_we = 1'b1; fwd_wa = r_bwd_q; fwd_wd = r_fwd_q;
                    bwd_we = 1'b1; bwd_wa = r_fwd_q; bwd_wd = r_bwd_q;
                    if (r_cur == r_head) n_head = r_fwd_q;
                    if (r_cur == r_tail) n_tail = r_bwd_q;
                end
                n_count = r_count - 1'b1;
                free_we = 1'b1; free_wa = SW'(r_top); free_wd = r_cur;
                n_top   = r_top + 1'b1;
                n_res_pos = r_pos;
                n_res_val = shown(r_val_q);
            end
            pel_pkg::S_RESP: begin
                if (out_free) n_o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (val_we)  m_val[val_wa]   <= val_wd;
        if (fwd_we)  m_fwd[fwd_wa]   <= fwd_wd;
        if (bwd_we)  m_bwd[bwd_wa]   <= bwd_wd;
        if (free_we) m_free[free_wa] <= free_wd;
        r_val_q  <= m_val[val_ra];
        r_fwd_q  <= m_fwd[fwd_ra];
        r_bwd_q  <= m_bwd[bwd_ra];
        r_free_q <= m_free[free_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pel_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_top     <= CW'(CAPACITY);
            r_low     <= CW'(CAPACITY);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_top     <= n_top;
            r_low     <= n_low;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins        <= n_ins;
        r_first      <= n_first;
        r_pos        <= n_pos;
        r_left       <= n_left;
        r_cur        <= n_cur;
        r_node       <= n_node;
        r_next       <= n_next;
        r_sval       <= n_sval;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_val    <= n_res_val;
        if (r_state == pel_pkg::S_RESP && out_free) begin
            r_o_status <= r_res_status;
            r_o_pos    <= 7'(r_res_pos);
            r_o_val    <= r_res_val;
            r_o_total  <= 7'(r_count);
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_result_position = r_o_pos;
    assign o_result_value    = r_o_val;
    assign o_entry_total     = r_o_total;

    `PEL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `PEL_ASSERT_IMPL(a_free_balance, 1'b1, (CW + 1)'(r_count) + (CW + 1)'(r_top) == (CW + 1)'(CAPACITY))
    `PEL_ASSERT_IMPL(a_low_mark, 1'b1, r_low <= r_top)
    `PEL_ASSERT_NEXT(a_walk_ends, r_state == pel_pkg::S_WALK && r_left == '0, r_state == pel_pkg::S_INS_RD || r_state == pel_pkg::S_DEL_RD)

endmodule
